// ===== rtl/core/sap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the skyline atlas placer.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PT_W       = 32;

    localparam logic [14:0] RESET_PAGE_WIDTH = 15'd1024;

    localparam logic [2:0] REG_PAGE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT_LIMIT  = 3'd1;
    localparam logic [2:0] REG_BORDER_LEFT   = 3'd2;
    localparam logic [2:0] REG_BORDER_TOP    = 3'd3;
    localparam logic [2:0] REG_BORDER_RIGHT  = 3'd4;
    localparam logic [2:0] REG_BORDER_BOTTOM = 3'd5;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_CMP,
        ST_WRAP,
        ST_JOIN_RD,
        ST_JOIN_WR,
        ST_JOIN_END,
        ST_Y_RD,
        ST_Y_SEL,
        ST_PLACE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic init_wr;
        logic load_in;
        logic set_ovs;
        logic pop;
        logic wrap;
        logic join_wr;
        logic join_end;
        logic y_sel;
        logic place;
        logic done_load;
    } t_cmd;

    typedef struct packed {
        logic oversize;
        logic pop_go;
        logic wrap_go;
        logic join_more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/sap_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer: walks one rectangle through pop, wrap/join, row and place steps.
// ----------------------------------------------------------------------------
module sap_ctrl
    import sap_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:     n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK:    n_state = i_sts.oversize ? ST_DONE : ST_POP_RD;
            ST_POP_RD:   n_state = ST_POP_CMP;
            ST_POP_CMP:  n_state = i_sts.pop_go ? ST_POP_RD : ST_WRAP;
            ST_WRAP:     n_state = i_sts.wrap_go ? ST_JOIN_RD : ST_Y_RD;
            ST_JOIN_RD:  n_state = i_sts.join_more ? ST_JOIN_WR : ST_JOIN_END;
            ST_JOIN_WR:  n_state = ST_JOIN_RD;
            ST_JOIN_END: n_state = ST_Y_RD;
            ST_Y_RD:     n_state = ST_Y_SEL;
            ST_Y_SEL:    n_state = ST_PLACE;
            ST_PLACE:    n_state = ST_DONE;
            ST_DONE:     if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: o_cmd.init_wr = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_CHECK:    o_cmd.set_ovs = i_sts.oversize;
            ST_POP_CMP:  o_cmd.pop = i_sts.pop_go;
            ST_WRAP:     o_cmd.wrap = i_sts.wrap_go;
            ST_JOIN_RD:  o_cmd.join_wr = 1'b0;
            ST_JOIN_WR:  o_cmd.join_wr = 1'b1;
            ST_JOIN_END: o_cmd.join_end = 1'b1;
            ST_Y_SEL:    o_cmd.y_sel = 1'b1;
            ST_PLACE:    o_cmd.place = 1'b1;
            ST_DONE:     o_cmd.done_load = i_sts.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/sap_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_dp
// Datapath: config registers, two banked point queues, cursor and page state.
// ----------------------------------------------------------------------------
module sap_dp
    import sap_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [14:0] i_cfg_data,
    input  wire  [47:0] i_in_data,
    input  wire  t_cmd  i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [79:0] o_out_data
);

    logic [14:0] r_pw, r_lim;
    logic [7:0]  r_bl, r_bt, r_br, r_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw  <= RESET_PAGE_WIDTH;
            r_lim <= '0;
            r_bl  <= '0;
            r_bt  <= '0;
            r_br  <= '0;
            r_bb  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PAGE_WIDTH:    r_pw  <= i_cfg_data;
                REG_HEIGHT_LIMIT:  r_lim <= i_cfg_data;
                REG_BORDER_LEFT:   r_bl  <= i_cfg_data[7:0];
                REG_BORDER_TOP:    r_bt  <= i_cfg_data[7:0];
                REG_BORDER_RIGHT:  r_br  <= i_cfg_data[7:0];
                REG_BORDER_BOTTOM: r_bb  <= i_cfg_data[7:0];
                default:           r_pw  <= r_pw;
            endcase
        end
    end

    logic [14:0] r_w, r_h;
    logic [15:0] r_tag;
    logic [15:0] r_x, r_y;
    logic        r_lost, r_ovs;

    logic             r_sel;
    logic [CNT_W-1:0] r_first, r_pc, r_cc, r_i;
    logic [15:0]      r_cursor;
    logic [7:0]       r_page;
    logic [14:0]      r_max;

    logic [PT_W-1:0] mem_a [MAX_POINTS];
    logic [PT_W-1:0] mem_b [MAX_POINTS];
    logic [PT_W-1:0] r_rd_a, r_rd_b;
    logic [PT_W-1:0] rdata;
    logic [IDX_W-1:0] rd_addr;

    assign rd_addr = r_first[IDX_W-1:0] + r_i[IDX_W-1:0];
    assign rdata   = r_sel ? r_rd_b : r_rd_a;

    // arithmetic
    logic signed [17:0] cur_ext, cur_sum, y_ext, y_sum, ny_sum;
    logic [CNT_W:0]     tot;
    logic [CNT_W-1:0]   room, join_n;
    logic [15:0]        y_cand, y_new, cur_neg, ny;
    logic               page_go;

    assign cur_ext = $signed({{2{r_cursor[15]}}, r_cursor});
    assign cur_sum = cur_ext + $signed({3'd0, r_w}) + $signed({10'd0, r_br});
    assign cur_neg = 16'd0 - {8'd0, r_bl};

    assign y_cand  = (r_pc != '0) ? rdata[31:16] : {1'b0, r_max};
    assign y_ext   = $signed({{2{y_cand[15]}}, y_cand});
    assign y_sum   = y_ext + $signed({3'd0, r_h}) + $signed({10'd0, r_bb});
    assign page_go = (r_lim != '0) && (y_sum > $signed({3'd0, r_lim}));
    assign y_new   = page_go ? (16'd0 - {8'd0, r_bt}) : y_cand;

    assign ny_sum  = $signed({{2{r_y[15]}}, r_y}) + $signed({3'd0, r_h})
                   + $signed({10'd0, r_bb});
    assign ny      = (ny_sum > 18'sd32767) ? 16'd32767 : ny_sum[15:0];

    assign tot     = {1'b0, r_cc} + {1'b0, r_pc};
    assign room    = CNT_W'(MAX_POINTS) - r_cc;
    assign join_n  = (r_pc <= room) ? r_pc : room;

    assign o_sts.oversize  = (r_w > r_pw) || ((r_lim != '0) && (r_h > r_lim));
    assign o_sts.pop_go    = (r_pc != '0) && ($signed(rdata[15:0]) < $signed(r_cursor));
    assign o_sts.wrap_go   = cur_sum > $signed({3'd0, r_pw});
    assign o_sts.join_more = r_i < join_n;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    // write ports, expressed as prev/cur then mapped to banks
    logic             we_prev, we_cur;
    logic [IDX_W-1:0] wa_cur;
    logic [PT_W-1:0]  wd_prev, wd_cur;
    logic [15:0]      cur_next;

    assign cur_next = (cur_sum > 18'sd32767) ? 16'd32767 : cur_sum[15:0];

    always_comb begin
        we_prev = i_cmd.init_wr || (i_cmd.y_sel && page_go);
        wd_prev = {16'd0, 1'b0, (i_cmd.init_wr ? RESET_PAGE_WIDTH : r_pw)};
        we_cur  = i_cmd.join_wr || (i_cmd.place && (r_cc < CNT_W'(MAX_POINTS)));
        wa_cur  = i_cmd.join_wr ? (r_cc[IDX_W-1:0] + r_i[IDX_W-1:0]) : r_cc[IDX_W-1:0];
        wd_cur  = i_cmd.join_wr ? rdata : {ny, cur_next};
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= mem_a[rd_addr];
        r_rd_b <= mem_b[rd_addr];
        if ((we_prev && !r_sel) || (we_cur && r_sel)) begin
            mem_a[we_prev ? '0 : wa_cur] <= we_prev ? wd_prev : wd_cur;
        end
        if ((we_prev && r_sel) || (we_cur && !r_sel)) begin
            mem_b[we_prev ? '0 : wa_cur] <= we_prev ? wd_prev : wd_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_first     <= '0;
            r_pc        <= CNT_W'(1);
            r_cc        <= '0;
            r_i         <= '0;
            r_cursor    <= '0;
            r_page      <= '0;
            r_max       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.load_in) begin
                r_i <= '0;
            end
            if (i_cmd.pop) begin
                r_first <= r_first + CNT_W'(1);
                r_pc    <= r_pc - CNT_W'(1);
            end
            if (i_cmd.wrap) begin
                r_cursor <= cur_neg;
                r_i      <= '0;
            end
            if (i_cmd.join_wr) r_i <= r_i + CNT_W'(1);
            if (i_cmd.join_end) begin
                r_sel   <= ~r_sel;
                r_first <= '0;
                r_pc    <= (tot > (CNT_W+1)'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : tot[CNT_W-1:0];
                r_cc    <= '0;
                r_i     <= '0;
            end
            if (i_cmd.y_sel && page_go) begin
                r_page   <= r_page + 8'd1;
                r_cursor <= cur_neg;
                r_first  <= '0;
                r_pc     <= CNT_W'(1);
                r_cc     <= '0;
                r_max    <= '0;
            end
            if (i_cmd.place) begin
                r_cursor <= cur_next;
                if ($signed(ny) > $signed({1'b0, r_max})) r_max <= ny[14:0];
                if (r_cc < CNT_W'(MAX_POINTS)) r_cc <= r_cc + CNT_W'(1);
            end
            if (i_cmd.done_load) o_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_w    <= i_in_data[14:0];
            r_h    <= i_in_data[29:15];
            r_tag  <= i_in_data[45:30];
            r_lost <= 1'b0;
            r_ovs  <= 1'b0;
            r_x    <= '0;
            r_y    <= '0;
        end
        if (i_cmd.set_ovs) r_ovs <= 1'b1;
        if (i_cmd.join_end && (tot > (CNT_W+1)'(MAX_POINTS))) r_lost <= 1'b1;
        if (i_cmd.y_sel) r_y <= y_new;
        if (i_cmd.place) begin
            r_x <= r_cursor;
            if (r_cc >= CNT_W'(MAX_POINTS)) r_lost <= 1'b1;
        end
        if (i_cmd.done_load) begin
            o_out_data <= {7'd0, r_tag, r_lost, r_ovs, r_max, r_y, r_x, r_page};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/skyline_atlas_placer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_atlas_placer_unit
// Skyline rectangle placer for atlas pages, one result beat per input beat.
// ----------------------------------------------------------------------------
// One rectangle is in work at a time. A beat steps from accept through check,
// the pop of skyline points from the previous row and, on a row wrap, the copy
// into the joined row, then row select, place and done, each point read paced
// by the single read port of the point queues; an oversize beat goes from check
// to done. After reset the block seeds the first skyline point before it takes
// a beat. A finished result waits in the output register; the next beat is
// taken meanwhile, and its last step holds until the output register is free.
module skyline_atlas_placer_unit
    import sap_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [14:0] i_cfg_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,  // rect_width, rect_height, rect_tag
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // page_number, pos_x, pos_y, page_height, oversize, queue_overflow, tag_out
    output logic [79:0] o_m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    sap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
